FILE: hw/rtl/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg
// Shared types and constants for the binary to ASCII decimal converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2a_pkg;

    typedef logic [3:0] bcd_digit_t;

    localparam logic [5:0] ASCII_ZERO     = 6'd48;
    localparam bcd_digit_t DABBLE_LIMIT   = 4'd5;
    localparam bcd_digit_t DABBLE_ADD     = 4'd3;
    localparam bcd_digit_t DIGIT_MAX      = 4'd9;

endpackage

`default_nettype wire

FILE: hw/rtl/b2a_dabble_stage.sv
// ----------------------------------------------------------------------------
// b2a_dabble_stage
// One register stage of the shift-and-add-3 conversion: consumes BITS
// binary bits, most significant first, into the packed BCD accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_dabble_stage
    import b2a_pkg::*;
#(
    parameter int DIGITS = 10,
    parameter int BITS   = 4,
    parameter int PADW   = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [4*DIGITS-1:0]   in_bcd,
    input  wire logic [PADW-1:0]       in_bin,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [4*DIGITS-1:0]        out_bcd,
    output logic [PADW-1:0]            out_bin
);

    localparam int BCDW = 4 * DIGITS;

    logic              valid_reg, valid_next;
    logic [BCDW-1:0]   bcd_reg, bcd_next;
    logic [PADW-1:0]   bin_reg, bin_next;
    logic              load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;

    always_comb begin
        bcd_digit_t d;
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int b = 0; b < BITS; b++) begin
            // adjust every digit that would overflow on doubling, then shift
            for (int k = 0; k < DIGITS; k++) begin
                d = bcd_next[4*k +: 4];
                if (d >= DABBLE_LIMIT) begin
                    bcd_next[4*k +: 4] = d + DABBLE_ADD;
                end
            end
            bcd_next = {bcd_next[BCDW-2:0], bin_next[PADW-1]};
            bin_next = {bin_next[PADW-2:0], 1'b0};
        end
    end

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(bcd_reg) && $stable(bin_reg)))
        else $error("stalled item changed in dabble stage");
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> valid_reg)
        else $error("loaded item lost in dabble stage");
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |-> !in_ready)
        else $error("dabble stage accepts while holding a stalled item");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/b2a_serializer.sv
// ----------------------------------------------------------------------------
// b2a_serializer
// Holds one converted BCD value and sends its digits as ASCII, most
// significant nonzero digit first, one item per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_serializer
    import b2a_pkg::*;
#(
    parameter int DIGITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [4*DIGITS-1:0]   in_bcd,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [5:0]                 m_digit_char,
    output logic                       m_last_digit
);

    localparam int IDXW = $clog2(DIGITS);

    logic                  busy_reg, busy_next;
    logic [IDXW-1:0]       idx_reg, idx_next;
    logic [4*DIGITS-1:0]   bcd_reg;
    logic [IDXW-1:0]       msd;
    logic                  load;
    logic                  at_last;
    bcd_digit_t            cur_digit;

    assign at_last  = (idx_reg == '0);
    assign in_ready = !busy_reg || (m_ready && at_last);
    assign load     = in_valid && in_ready;

    // find the most significant nonzero digit; zero gives index 0
    always_comb begin
        msd = '0;
        for (int i = 1; i < DIGITS; i++) begin
            if (in_bcd[4*i +: 4] != '0) begin
                msd = IDXW'(i);
            end
        end
    end

    assign cur_digit    = bcd_reg[4*idx_reg +: 4];
    assign m_valid      = busy_reg;
    assign m_digit_char = ASCII_ZERO + {2'b00, cur_digit};
    assign m_last_digit = at_last;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = msd;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bcd_reg <= in_bcd;
        end
    end

`ifndef NO_ASSERTIONS
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (cur_digit <= DIGIT_MAX))
        else $error("digit out of decimal range");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded value not presented");
    a_run_unbroken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_digit) |=> m_valid)
        else $error("digit run broken before last digit");
    a_no_load_midrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !at_last) |-> !in_ready)
        else $error("new value accepted in the middle of a run");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/binary_to_ascii_decimal_top.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_decimal_top
// A value passes the registered dabble stages and the serializer register before
// its first digit. The digit serializer, sending 1 to 10 digits at 32 bits, sets
// throughput; the conversion pipeline takes a value a cycle unless stalled.
// Reset: synchronous active-low aresetn clears all valid and run state.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_ascii_decimal_top
    import b2a_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [VALUE_WIDTH-1:0]  s_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [5:0]                   m_digit_char,
    output logic                         m_last_digit
);

    localparam int BITS   = 4;
    localparam int NSTAGE = (VALUE_WIDTH + BITS - 1) / BITS;
    localparam int PADW   = NSTAGE * BITS;
    localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCDW   = 4 * DIGITS;

    logic              valid_w [0:NSTAGE];
    logic              ready_w [0:NSTAGE];
    logic [BCDW-1:0]   bcd_w   [0:NSTAGE];
    logic [PADW-1:0]   bin_w   [0:NSTAGE];

    assign valid_w[0] = s_valid;
    assign s_ready    = ready_w[0];
    assign bcd_w[0]   = '0;
    assign bin_w[0]   = PADW'(s_value);

    for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
        b2a_dabble_stage #(
            .DIGITS (DIGITS),
            .BITS   (BITS),
            .PADW   (PADW)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[g]),
            .in_ready  (ready_w[g]),
            .in_bcd    (bcd_w[g]),
            .in_bin    (bin_w[g]),
            .out_valid (valid_w[g+1]),
            .out_ready (ready_w[g+1]),
            .out_bcd   (bcd_w[g+1]),
            .out_bin   (bin_w[g+1])
        );
    end

    b2a_serializer #(
        .DIGITS (DIGITS)
    ) u_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (valid_w[NSTAGE]),
        .in_ready     (ready_w[NSTAGE]),
        .in_bcd       (bcd_w[NSTAGE]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

endmodule

`default_nettype wire
